@@ rtl/core/lifestep_pkg.sv @@
// Shared types and constants for the Life generation step unit.
// Holds the command codes, register indexes, the in/out word structs and
// the control struct between the sequencer and the cell unit. No dependencies.
package lifestep_pkg;

  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;

  localparam int CfgW     = 9;
  localparam int CellIdxW = 16;
  localparam int AliveW   = 17;
  localparam int GenW     = 32;

  localparam logic [CfgW-1:0] BoardWidthRst  = 9'd160;
  localparam logic [CfgW-1:0] BoardHeightRst = 9'd160;

  // B3/S23 neighbor counts
  localparam logic [3:0] LiveBirth = 4'd3;
  localparam logic [3:0] LiveKeep  = 4'd2;

  typedef enum logic [1:0] {
    CMD_TOGGLE = 2'd0,
    CMD_STEP   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_BOARD_WIDTH  = 1'b0,
    REG_BOARD_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t                command;
    logic [CellIdxW-1:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic              cell_state;
    logic [AliveW-1:0] alive_count;
    logic [GenW-1:0]   generation;
    logic              index_error;
  } out_word_t;

  // one scan slot in flight between fetch and evaluate
  typedef struct packed {
    logic slot;     // slot valid
    logic fetch;    // column inside the board
    logic first;    // first slot of a row
    logic compute;  // slot produces a cell
    logic top_ok;   // row above exists
    logic mid_ok;   // current row exists
    logic bot_ok;   // row below exists
  } cell_ctl_t;

endpackage

@@ rtl/core/lifestep_ram.sv @@
// Generic one-bit RAM: one write port, one read port, registered read data.
// Used for the cell grid and the two row buffers. No dependencies.
module lifestep_ram #(
  parameter int DEPTH = 4,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem_r [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/lifestep_cell_unit.sv @@
// Neighborhood window and B3/S23 rule evaluation, one cell per scan slot.
// Takes the fetched column from the row buffers and the grid. Uses lifestep_pkg.
module lifestep_cell_unit
  import lifestep_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      lb0_q,
  input  logic      lb1_q,
  input  logic      grid_q,
  output logic      col_mid,
  output logic      col_bot,
  output logic      nv,
  output logic      nv_valid
);

  // bit 0 row above, bit 1 current row, bit 2 row below
  logic [2:0] win_l_r;
  logic [2:0] win_c_r;
  logic [2:0] col_c;
  logic       col_top;
  logic       live_col;
  logic [3:0] cnt_c;

  assign live_col = ctl.slot & ctl.fetch;
  assign col_top  = live_col & ctl.top_ok & lb0_q;
  assign col_mid  = live_col & ctl.mid_ok & lb1_q;
  assign col_bot  = live_col & ctl.bot_ok & grid_q;
  assign col_c    = {col_bot, col_mid, col_top};

  always_ff @(posedge clk) begin
    if (ctl.slot) begin
      win_l_r <= ctl.first ? 3'b000 : win_c_r;
      win_c_r <= col_c;
    end
  end

  // window holds columns x-1 and x; the fresh column is x+1
  assign cnt_c = {3'b000, win_l_r[0]} + {3'b000, win_l_r[1]} + {3'b000, win_l_r[2]}
               + {3'b000, win_c_r[0]} + {3'b000, win_c_r[2]}
               + {3'b000, col_c[0]}   + {3'b000, col_c[1]}   + {3'b000, col_c[2]};

  assign nv       = (cnt_c == LiveBirth) || (win_c_r[1] && (cnt_c == LiveKeep));
  assign nv_valid = ctl.slot & ctl.compute;

endmodule

@@ rtl/core/life_automaton_generation_step_unit.sv @@
// Bounded Life (B3/S23) engine: cell grid, row buffers and command sequencer.
// One command per word; a single grid RAM port pair is time-shared by all
// commands. Uses lifestep_pkg, lifestep_ram and lifestep_cell_unit.
//
// After reset the grid is cleared by a sweep during which in_ready stays
// low; configuration writes are taken at any time. Commands run one at a
// time: toggle and read fetch the addressed cell from the grid, toggle
// writing it back inverted; clear sweeps the whole grid; and step scans
// the in-use board of w by h with one scan slot per cycle through the grid
// RAM (one cell fetched, one cell written), then a sweep kills every cell
// outside the in-use area. The generated word waits in an output register;
// a new command is accepted while it waits.
module life_automaton_generation_step_unit
  import lifestep_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_word_t        in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output out_word_t       out_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [0:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_wdata
);

  localparam int GridCells = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(GridCells);
  localparam int TW = $clog2(GridCells + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int LW = $clog2(MAX_WIDTH);
  localparam int CW = (WW > CfgW) ? WW : CfgW;
  localparam int CH = (HW > CfgW) ? HW : CfgW;
  localparam int IW = (TW > CellIdxW) ? TW : CellIdxW;
  localparam logic [AW:0] SweepEnd = (AW + 1)'(GridCells);

  typedef enum logic [8:0] {
    S_SWEEP  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_SIZE   = 9'b000000100,
    S_CHECK  = 9'b000001000,
    S_STEP   = 9'b000010000,
    S_DRAIN  = 9'b000100000,
    S_ACCESS = 9'b001000000,
    S_RMW    = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CfgW-1:0]   w_cfg_r, w_cfg_nxt;
  logic [CfgW-1:0]   h_cfg_r, h_cfg_nxt;
  in_word_t          in_r, in_nxt;
  logic [WW-1:0]     w_eff_r, w_eff_nxt;
  logic [HW-1:0]     h_eff_r, h_eff_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic              inside_r, inside_nxt;
  logic [GenW-1:0]   gen_r, gen_nxt;
  logic [AliveW-1:0] alive_r, alive_nxt;
  logic [AliveW-1:0] alive_cnt_r, alive_cnt_nxt;
  logic [AW:0]       sweep_r, sweep_nxt;
  logic              rst_pass_r, rst_pass_nxt;
  logic [HW-1:0]     rc_r, rc_nxt;
  logic [WW-1:0]     k_r, k_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  cell_ctl_t         ctl_r, ctl_nxt;
  logic [LW-1:0]     lb_col_r, lb_col_nxt;
  logic              cell_r, cell_nxt;
  out_word_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CW-1:0]     w_raw_c;
  logic [CH-1:0]     h_raw_c;
  logic [WW-1:0]     w_eff_c;
  logic [HW-1:0]     h_eff_c;
  logic [WW+HW-1:0]  prod_c;
  logic              inside_c;
  logic [AW-1:0]     idx_addr_c;
  logic              fetch_c;
  logic              bot_ok_c;

  logic              g_we, g_wdata, g_re, g_rdata;
  logic [AW-1:0]     g_waddr, g_raddr;
  logic              lb_re, lb_we;
  logic              lb0_q, lb1_q;
  logic              col_mid, col_bot;
  logic              nv, nv_valid;

  // size registers: zero reads as one, oversize saturates
  assign w_raw_c = CW'(w_cfg_r);
  assign h_raw_c = CH'(h_cfg_r);

  always_comb begin
    if (w_raw_c == '0) begin
      w_eff_c = WW'(1);
    end else if (w_raw_c > CW'(MAX_WIDTH)) begin
      w_eff_c = WW'(MAX_WIDTH);
    end else begin
      w_eff_c = WW'(w_raw_c);
    end
    if (h_raw_c == '0) begin
      h_eff_c = HW'(1);
    end else if (h_raw_c > CH'(MAX_HEIGHT)) begin
      h_eff_c = HW'(MAX_HEIGHT);
    end else begin
      h_eff_c = HW'(h_raw_c);
    end
  end

  assign prod_c     = w_eff_r * h_eff_r;
  assign inside_c   = IW'(in_r.cell_index) < IW'(total_r);
  assign idx_addr_c = AW'(in_r.cell_index);
  assign fetch_c    = k_r < w_eff_r;
  assign bot_ok_c   = rc_r < h_eff_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign lb_we     = ctl_r.slot & ctl_r.fetch;

  always_comb begin
    state_nxt     = state_r;
    w_cfg_nxt     = w_cfg_r;
    h_cfg_nxt     = h_cfg_r;
    in_nxt        = in_r;
    w_eff_nxt     = w_eff_r;
    h_eff_nxt     = h_eff_r;
    total_nxt     = total_r;
    inside_nxt    = inside_r;
    gen_nxt       = gen_r;
    alive_nxt     = alive_r;
    alive_cnt_nxt = alive_cnt_r;
    sweep_nxt     = sweep_r;
    rst_pass_nxt  = rst_pass_r;
    rc_nxt        = rc_r;
    k_nxt         = k_r;
    rd_addr_nxt   = rd_addr_r;
    wr_addr_nxt   = wr_addr_r;
    ctl_nxt       = '0;
    lb_col_nxt    = lb_col_r;
    cell_nxt      = cell_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    g_we          = 1'b0;
    g_waddr       = wr_addr_r;
    g_wdata       = 1'b0;
    g_re          = 1'b0;
    g_raddr       = rd_addr_r;
    lb_re         = 1'b0;

    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_BOARD_WIDTH:  w_cfg_nxt = cfg_wdata;
        REG_BOARD_HEIGHT: h_cfg_nxt = cfg_wdata;
        default:          w_cfg_nxt = w_cfg_r;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // evaluate stage of the scan, one column behind the fetch
    if (nv_valid) begin
      g_we          = 1'b1;
      g_waddr       = wr_addr_r;
      g_wdata       = nv;
      wr_addr_nxt   = wr_addr_r + AW'(1);
      alive_cnt_nxt = alive_cnt_r + AliveW'(nv);
    end

    case (state_r)
      S_SWEEP: begin
        if (sweep_r == SweepEnd) begin
          rst_pass_nxt = 1'b0;
          if (rst_pass_r) begin
            state_nxt = S_IDLE;
          end else if (in_r.command == CMD_STEP) begin
            gen_nxt   = gen_r + GenW'(1);
            alive_nxt = alive_cnt_r;
            state_nxt = S_ACCESS;
          end else begin
            gen_nxt   = '0;
            cell_nxt  = 1'b0;
            state_nxt = S_FIN;
          end
        end else begin
          g_we      = 1'b1;
          g_waddr   = sweep_r[AW-1:0];
          g_wdata   = 1'b0;
          sweep_nxt = sweep_r + (AW + 1)'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_word;
          w_eff_nxt = w_eff_c;
          h_eff_nxt = h_eff_c;
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        total_nxt = TW'(prod_c);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        inside_nxt = inside_c;
        case (in_r.command)
          CMD_TOGGLE, CMD_READ: state_nxt = S_ACCESS;
          CMD_STEP: begin
            rc_nxt        = '0;
            k_nxt         = '0;
            rd_addr_nxt   = '0;
            wr_addr_nxt   = '0;
            alive_cnt_nxt = '0;
            state_nxt     = S_STEP;
          end
          CMD_CLEAR: begin
            sweep_nxt = '0;
            state_nxt = S_SWEEP;
          end
          default: state_nxt = S_ACCESS;
        endcase
      end
      S_STEP: begin
        // row counter rc is the row being fetched; the row evaluated is rc-1
        ctl_nxt.slot    = 1'b1;
        ctl_nxt.fetch   = fetch_c;
        ctl_nxt.first   = (k_r == '0);
        ctl_nxt.compute = (k_r != '0) && (rc_r != '0);
        ctl_nxt.top_ok  = rc_r > HW'(1);
        ctl_nxt.mid_ok  = rc_r != '0;
        ctl_nxt.bot_ok  = bot_ok_c;
        lb_re           = fetch_c;
        lb_col_nxt      = k_r[LW-1:0];
        g_re            = fetch_c && bot_ok_c;
        if (fetch_c && bot_ok_c) begin
          rd_addr_nxt = rd_addr_r + AW'(1);
        end
        if (k_r == w_eff_r) begin
          k_nxt = '0;
          if (rc_r == h_eff_r) begin
            state_nxt = S_DRAIN;
          end else begin
            rc_nxt = rc_r + HW'(1);
          end
        end else begin
          k_nxt = k_r + WW'(1);
        end
      end
      S_DRAIN: begin
        // cells beyond the in-use area are killed by the sweep
        sweep_nxt = (AW + 1)'(total_r);
        state_nxt = S_SWEEP;
      end
      S_ACCESS: begin
        g_re      = 1'b1;
        g_raddr   = idx_addr_c;
        state_nxt = S_RMW;
      end
      S_RMW: begin
        if ((in_r.command == CMD_TOGGLE) && inside_r) begin
          g_we     = 1'b1;
          g_waddr  = idx_addr_c;
          g_wdata  = ~g_rdata;
          cell_nxt = ~g_rdata;
        end else begin
          cell_nxt = inside_r & g_rdata;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.cell_state  = cell_r;
          out_nxt.alive_count = alive_r;
          out_nxt.generation  = gen_r;
          out_nxt.index_error = ~inside_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      w_cfg_r     <= BoardWidthRst;
      h_cfg_r     <= BoardHeightRst;
      gen_r       <= '0;
      alive_r     <= '0;
      sweep_r     <= '0;
      rst_pass_r  <= 1'b1;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_cfg_r     <= w_cfg_nxt;
      h_cfg_r     <= h_cfg_nxt;
      gen_r       <= gen_nxt;
      alive_r     <= alive_nxt;
      sweep_r     <= sweep_nxt;
      rst_pass_r  <= rst_pass_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    w_eff_r     <= w_eff_nxt;
    h_eff_r     <= h_eff_nxt;
    total_r     <= total_nxt;
    inside_r    <= inside_nxt;
    alive_cnt_r <= alive_cnt_nxt;
    rc_r        <= rc_nxt;
    k_r         <= k_nxt;
    rd_addr_r   <= rd_addr_nxt;
    wr_addr_r   <= wr_addr_nxt;
    lb_col_r    <= lb_col_nxt;
    cell_r      <= cell_nxt;
    out_r       <= out_nxt;
  end

  lifestep_ram #(
    .DEPTH (GridCells)
  ) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // row above the evaluated row
  lifestep_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_row_above (
    .clk   (clk),
    .we    (lb_we),
    .waddr (lb_col_r),
    .wdata (col_mid),
    .re    (lb_re),
    .raddr (k_r[LW-1:0]),
    .rdata (lb0_q)
  );

  // evaluated row
  lifestep_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_row_mid (
    .clk   (clk),
    .we    (lb_we),
    .waddr (lb_col_r),
    .wdata (col_bot),
    .re    (lb_re),
    .raddr (k_r[LW-1:0]),
    .rdata (lb1_q)
  );

  lifestep_cell_unit u_cell (
    .clk      (clk),
    .ctl      (ctl_r),
    .lb0_q    (lb0_q),
    .lb1_q    (lb1_q),
    .grid_q   (g_rdata),
    .col_mid  (col_mid),
    .col_bot  (col_bot),
    .nv       (nv),
    .nv_valid (nv_valid)
  );

endmodule

@@ rtl/core/lifestep_checker.sv @@
// Port-level checks for the Life generation step unit, bound to its top level.
// Uses lifestep_pkg for the result word type.
module lifestep_checker
  import lifestep_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // outside the board the cell always reads dead
  a_err_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.index_error && out_word.cell_state))
    else $error("cell_state set with index_error");

  // one command at a time: busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while busy");

  // a result only appears at the end of a busy period
  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a command in flight");

endmodule

bind life_automaton_generation_step_unit lifestep_checker u_lifestep_checker (.*);

@@ tb/life_automaton_generation_step_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for life_automaton_generation_step_unit: a shadow Life board
// predicts every result word, and a clocked driver and monitor run the handshakes.
// Depends on lifestep_pkg and the step unit RTL.
module life_automaton_generation_step_unit_tb;
  import lifestep_pkg::*;

  localparam int MaxW       = DefMaxWidth;
  localparam int MaxH       = DefMaxHeight;
  localparam int GridCells  = MaxW * MaxH;
  localparam int StallLimit = 400000;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  in_word_t        in_word   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_word_t       out_word;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [0:0]      cfg_index = '0;
  logic [CfgW-1:0] cfg_wdata = '0;

  life_automaton_generation_step_unit u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the board and its counters
  bit              shadow_cells [GridCells];
  bit              next_cells [GridCells];
  logic [GenW-1:0]   shadow_gen   = '0;
  logic [AliveW-1:0] shadow_alive = '0;
  logic [CfgW-1:0]   width_reg    = BoardWidthRst;
  logic [CfgW-1:0]   height_reg   = BoardHeightRst;

  out_word_t pending_results [$];
  in_word_t  cmd_backlog [$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  bit in_took        = 1'b0;
  bit idle_on        = 1'b1;
  int src_gap        = 0;
  int snk_gap        = 0;
  int hold_left      = 0;
  int plan_w         = 160;
  int plan_h         = 160;

  function automatic int eff_dim(logic [CfgW-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // applies one command word to the shadow board and queues the word it returns
  task automatic apply_command(in_word_t w);
    int bw, bh, idx, nx, ny, cnt, alive;
    bit in_board;
    out_word_t res;
    bw = eff_dim(width_reg, MaxW);
    bh = eff_dim(height_reg, MaxH);
    idx = int'(w.cell_index);
    in_board = idx < bw * bh;
    case (w.command)
      CMD_TOGGLE: if (in_board) shadow_cells[idx] = !shadow_cells[idx];
      CMD_STEP: begin
        alive = 0;
        for (int n = 0; n < GridCells; n++) begin
          next_cells[n] = 1'b0;
          if (n < bw * bh) begin
            cnt = 0;
            for (int dy = -1; dy <= 1; dy++)
              for (int dx = -1; dx <= 1; dx++) begin
                nx = n % bw + dx;
                ny = n / bw + dy;
                if ((dx != 0 || dy != 0) && nx >= 0 && nx < bw && ny >= 0 && ny < bh)
                  cnt += shadow_cells[ny * bw + nx];
              end
            if (cnt == LiveBirth || (shadow_cells[n] && cnt == LiveKeep)) begin
              next_cells[n] = 1'b1;
              alive++;
            end
          end
        end
        // cells outside the in-use area come out dead
        shadow_cells = next_cells;
        shadow_gen++;
        shadow_alive = alive[AliveW-1:0];
      end
      CMD_CLEAR: begin
        foreach (shadow_cells[n]) shadow_cells[n] = 1'b0;
        shadow_gen = '0;
      end
      default: ;
    endcase
    res.cell_state  = in_board ? shadow_cells[idx] : 1'b0;
    res.alive_count = shadow_alive;
    res.generation  = shadow_gen;
    res.index_error = !in_board;
    pending_results.push_back(res);
  endtask

  // monitor: samples both channels and the config port at the rising edge
  always @(posedge clk) begin
    out_word_t want;
    in_took = in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOARD_WIDTH:  width_reg  = cfg_wdata;
          REG_BOARD_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_took) apply_command(in_word);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", out_word));
        end else begin
          want = pending_results.pop_front();
          if (out_word.cell_state !== want.cell_state)
            report_mismatch($sformatf("cell_state %b, want %b",
                                      out_word.cell_state, want.cell_state));
          if (out_word.alive_count !== want.alive_count)
            report_mismatch($sformatf("alive_count %0d, want %0d",
                                      out_word.alive_count, want.alive_count));
          if (out_word.generation !== want.generation)
            report_mismatch($sformatf("generation %0d, want %0d",
                                      out_word.generation, want.generation));
          if (out_word.index_error !== want.index_error)
            report_mismatch($sformatf("index_error %b, want %b",
                                      out_word.index_error, want.index_error));
        end
      end
      if (in_took || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // command driver: next word goes up at a falling edge once the last one was taken, after an optional random gap
  always @(negedge clk) begin
    logic     nxt_valid;
    in_word_t nxt_word;
    nxt_valid = in_valid && !in_took;
    nxt_word  = in_word;
    if (!nxt_valid) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (cmd_backlog.size() != 0) begin
        nxt_word  = cmd_backlog.pop_front();
        nxt_valid = 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 18);
      end
    end
    in_valid <= nxt_valid;
    in_word  <= nxt_word;
  end

  // result receiver: random stall bursts plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 18);
    end
  end

  task automatic push_cmd(cmd_t c, int idx);
    in_word_t w;
    w.command    = c;
    w.cell_index = idx[CellIdxW-1:0];
    cmd_backlog.push_back(w);
  endtask

  task automatic write_board_reg(cfg_reg_t r, int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v[CfgW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_board(int wv, int hv);
    write_board_reg(REG_BOARD_WIDTH, wv);
    write_board_reg(REG_BOARD_HEIGHT, hv);
    plan_w = eff_dim(wv[CfgW-1:0], MaxW);
    plan_h = eff_dim(hv[CfgW-1:0], MaxH);
  endtask

  // every command returns a word, so an empty queue means the unit is idle
  task automatic wait_quiet();
    while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_dim(int maxv);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(maxv + 1, 511);
      2:       return maxv;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin
    int r, idx, cells;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset board size, corner indexes and the far end of the index range
    push_cmd(CMD_READ, 0);
    push_cmd(CMD_TOGGLE, 160 * 160 - 1);
    push_cmd(CMD_READ, 160 * 160 - 1);
    push_cmd(CMD_TOGGLE, 160 * 160);
    push_cmd(CMD_READ, 16'hFFFF);
    wait_quiet();

    // blinker on 5x5, then clear keeps the alive count
    set_board(5, 5);
    push_cmd(CMD_TOGGLE, 7);
    push_cmd(CMD_TOGGLE, 12);
    push_cmd(CMD_TOGGLE, 17);
    push_cmd(CMD_STEP, 12);
    push_cmd(CMD_READ, 11);
    push_cmd(CMD_STEP, 25);
    push_cmd(CMD_CLEAR, 12);
    push_cmd(CMD_READ, 12);
    wait_quiet();

    // zero sizes act as a single cell
    set_board(0, 0);
    push_cmd(CMD_TOGGLE, 0);
    push_cmd(CMD_TOGGLE, 1);
    push_cmd(CMD_STEP, 0);
    push_cmd(CMD_READ, 0);
    wait_quiet();

    // full board, oversized height saturates; block survives, lone corner dies
    set_board(MaxW, 511);
    push_cmd(CMD_TOGGLE, 65535);
    push_cmd(CMD_TOGGLE, 0);
    push_cmd(CMD_TOGGLE, 1);
    push_cmd(CMD_TOGGLE, 256);
    push_cmd(CMD_TOGGLE, 257);
    push_cmd(CMD_STEP, 65535);
    push_cmd(CMD_READ, 257);
    wait_quiet();

    // shrink with cells kept: the block is reread under the new width
    set_board(3, 1);
    push_cmd(CMD_READ, 1);
    push_cmd(CMD_STEP, 2);
    wait_quiet();

    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet();
      if (ph == 3) idle_on = 1'b0;
      set_board(pick_dim(MaxW), pick_dim(MaxH));
      if (ph == 1) hold_left = 400;
      cells = plan_w * plan_h;
      for (int k = 0; k < 25; k++) begin
        r = $urandom_range(0, 99);
        // keep the held-off stretch to short commands so the unit backs up
        if (ph == 1 && k < 10) r = r % 80;
        idx = ($urandom_range(0, 6) != 0) ? $urandom_range(0, cells - 1)
                                          : $urandom_range(0, 65535);
        if (r < 50)      push_cmd(CMD_TOGGLE, idx);
        else if (r < 88) push_cmd(CMD_READ, idx);
        else if (r < 98) push_cmd(CMD_STEP, idx);
        else             push_cmd(CMD_CLEAR, idx);
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
